### design/leader_point_clustering_top_assert.svh
// assertion macros for the leader point clustering block
// used by the checker module, no other dependencies
`ifndef LEADER_POINT_CLUSTERING_TOP_ASSERT_SVH
`define LEADER_POINT_CLUSTERING_TOP_ASSERT_SVH

`define LPC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define LPC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) \
        else $error("assertion failed");

`endif

### design/lpc_pkg.sv
// shared types and codes for the leader point clustering block
// no dependencies
package lpc_pkg;

    typedef enum logic [2:0] {
        ST_JOINED    = 3'd0,
        ST_NEW       = 3'd1,
        ST_FULL      = 3'd2,
        ST_NEAREST   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_SATURATED = 3'd5
    } status_t;

    localparam logic KIND_ADD     = 1'b0;
    localparam logic KIND_NEAREST = 1'b1;

    localparam int DIST_WIDTH   = 23;
    localparam int STATUS_WIDTH = 3;

endpackage

### design/leader_point_clustering_top.sv
// leader point clustering top level: table memory, scan and serial divide
// depends on lpc_pkg
//
// channel  dir  transfer content
// s_axis   in   tdata = {point_y, point_x}, tuser = kind
// m_axis   out  tdata = {clusters_in_use, center_y, center_x, status, cluster_index}
// cfg      in   cfg_data = min_distance
//
// an item is accepted, then each cluster scanned takes a memory read, a difference and a
// squared-distance compare, and a decide step follows; an empty table skips the scan
// a join adds a sum read and update and, unless the count is saturated, two restoring
// divides and a write-back step
// rst_n clears control state only; the table memory is not cleared
// a stalled m_axis holds the block; the next item is taken once the result leaves
module leader_point_clustering_top #(
    parameter int MAX_CLUSTERS = 64,
    parameter int COORD_WIDTH  = 24,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata, // point_x, point_y
    input  logic s_axis_tuser,                               // kind
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [(($clog2(MAX_CLUSTERS)+3+2*COORD_WIDTH+$clog2(MAX_CLUSTERS+1)+7)/8)*8-1:0]
        m_axis_tdata,
        // cluster_index, status, center_x, center_y, clusters_in_use
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [lpc_pkg::DIST_WIDTH-1:0] cfg_data
);
    localparam int IW = $clog2(MAX_CLUSTERS);
    localparam int TW = $clog2(MAX_CLUSTERS + 1);
    localparam int SW = COORD_WIDTH + COUNT_WIDTH;
    localparam int DW = 2 * COORD_WIDTH + 2;
    localparam int OW = ((IW + 3 + 2 * COORD_WIDTH + TW + 7) / 8) * 8;
    localparam int QW = SW;
    localparam int DCW = $clog2(QW + 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CMP, S_DECIDE, S_JREAD, S_JWAIT, S_JUPD, S_DIVX, S_DIVY,
        S_WRITE, S_OUT
    } state_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } cent_t;

    typedef struct packed {
        logic signed [SW-1:0]    sx;
        logic signed [SW-1:0]    sy;
        logic [COUNT_WIDTH-1:0]  cnt;
    } acc_t;

    cent_t cent_mem [MAX_CLUSTERS];
    acc_t  acc_mem  [MAX_CLUSTERS];

    state_t state_reg;
    logic [lpc_pkg::DIST_WIDTH-1:0] min_dist_reg;
    logic [TW-1:0] total_reg;
    logic kind_reg;
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic [TW-1:0] scan_reg;
    logic [IW-1:0] idx_reg;
    logic found_reg;
    logic [DW-1:0] best_reg;
    logic [DW-1:0] r2_reg;
    cent_t cent_rd_reg;
    acc_t  acc_rd_reg;
    cent_t best_cent_reg;
    logic signed [COORD_WIDTH-1:0] dx_reg, dy_reg;
    logic [DW-1:0] dist_reg;
    logic [IW-1:0] cmp_idx_reg;
    acc_t  acc_new_reg;
    logic [QW-1:0] num_reg;
    logic [QW-1:0] quo_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic neg_reg;
    logic [DCW-1:0] dcnt_reg;
    logic signed [COORD_WIDTH-1:0] qx_reg;
    logic [IW-1:0] o_idx_reg;
    lpc_pkg::status_t o_status_reg;
    logic signed [COORD_WIDTH-1:0] o_cx_reg, o_cy_reg;
    logic o_valid_reg;

    logic signed [COORD_WIDTH-1:0] in_x, in_y;
    logic signed [COORD_WIDTH:0] ddx, ddy;
    logic [2*COORD_WIDTH+1:0] sqx, sqy;
    logic [COUNT_WIDTH:0] rem_sh;
    logic [COUNT_WIDTH:0] rem_sub;
    logic [QW-1:0] num_abs;
    logic signed [COORD_WIDTH-1:0] q_signed;

    assign in_x = s_axis_tdata[COORD_WIDTH-1:0];
    assign in_y = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign s_axis_tready = (state_reg == S_IDLE) && !o_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata = OW'({total_reg, o_cy_reg, o_cx_reg, o_status_reg, o_idx_reg});

    assign ddx = {cent_rd_reg.cx[COORD_WIDTH-1], cent_rd_reg.cx} - {px_reg[COORD_WIDTH-1], px_reg};
    assign ddy = {cent_rd_reg.cy[COORD_WIDTH-1], cent_rd_reg.cy} - {py_reg[COORD_WIDTH-1], py_reg};
    assign sqx = $unsigned(dx_reg) * $unsigned(dx_reg);
    assign sqy = $unsigned(dy_reg) * $unsigned(dy_reg);
    assign rem_sh = {rem_reg, num_reg[QW-1]};
    assign rem_sub = rem_sh - {1'b0, acc_new_reg.cnt};
    assign num_abs = acc_new_reg.sx[SW-1] ? QW'(-acc_new_reg.sx) : QW'(acc_new_reg.sx);
    assign q_signed = neg_reg ? -COORD_WIDTH'(quo_reg) : COORD_WIDTH'(quo_reg);

    // absolute differences stored, so products are unsigned
    logic [COORD_WIDTH:0] adx, ady;
    assign adx = ddx[COORD_WIDTH] ? -ddx : ddx;
    assign ady = ddy[COORD_WIDTH] ? -ddy : ddy;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            cent_mem[idx_reg] <= '{cx: qx_reg, cy: q_signed};
            acc_mem[idx_reg]  <= acc_new_reg;
        end
        else if (state_reg == S_DECIDE && !found_reg && kind_reg == lpc_pkg::KIND_ADD
                 && total_reg < TW'(MAX_CLUSTERS))
        begin
            cent_mem[total_reg[IW-1:0]] <= '{cx: px_reg, cy: py_reg};
            acc_mem[total_reg[IW-1:0]]  <= '{sx: SW'(px_reg), sy: SW'(py_reg),
                cnt: COUNT_WIDTH'(1)};
        end
        if (state_reg == S_READ)
            cent_rd_reg <= cent_mem[scan_reg[IW-1:0]];
        acc_rd_reg  <= acc_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            min_dist_reg <= '0;
            total_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                min_dist_reg <= cfg_data;
            if (o_valid_reg && m_axis_tready)
                o_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        kind_reg <= s_axis_tuser;
                        px_reg <= in_x;
                        py_reg <= in_y;
                        scan_reg <= '0;
                        found_reg <= 1'b0;
                        idx_reg <= '0;
                        best_reg <= '1;
                        r2_reg <= DW'(min_dist_reg) * DW'(min_dist_reg);
                        state_reg <= (total_reg == '0) ? S_DECIDE : S_READ;
                    end
                end
                S_READ:
                begin
                    cmp_idx_reg <= scan_reg[IW-1:0];
                    scan_reg <= scan_reg + 1'b1;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    dx_reg <= COORD_WIDTH'(adx);
                    dy_reg <= COORD_WIDTH'(ady);
                    best_cent_reg <= best_cent_reg;
                    state_reg <= S_JWAIT;
                    // keep extra magnitude bit via dist computed next
                    dist_reg <= {adx[COORD_WIDTH] | ady[COORD_WIDTH], {(DW-1){1'b0}}};
                end
                S_JWAIT:
                begin
                    logic [DW-1:0] d;
                    d = (dist_reg[DW-1] ? {DW{1'b1}} : '0) | (DW'(sqx) + DW'(sqy));
                    if (kind_reg == lpc_pkg::KIND_ADD)
                    begin
                        if (d < r2_reg)
                        begin
                            found_reg <= 1'b1;
                            idx_reg <= cmp_idx_reg;
                            best_cent_reg <= cent_rd_reg;
                        end
                    end
                    else if (d < best_reg || cmp_idx_reg == '0)
                    begin
                        best_reg <= d;
                        idx_reg <= cmp_idx_reg;
                        best_cent_reg <= cent_rd_reg;
                    end
                    if ((kind_reg == lpc_pkg::KIND_ADD && d < r2_reg) || scan_reg >= total_reg)
                        state_reg <= S_DECIDE;
                    else
                        state_reg <= S_READ;
                end
                S_DECIDE:
                begin
                    if (kind_reg == lpc_pkg::KIND_ADD && found_reg)
                        state_reg <= S_JREAD;
                    else
                    begin
                        o_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                        if (kind_reg == lpc_pkg::KIND_NEAREST)
                        begin
                            if (total_reg == '0)
                            begin
                                o_status_reg <= lpc_pkg::ST_EMPTY;
                                o_idx_reg <= '0;
                                o_cx_reg <= '0;
                                o_cy_reg <= '0;
                            end
                            else
                            begin
                                o_status_reg <= lpc_pkg::ST_NEAREST;
                                o_idx_reg <= idx_reg;
                                o_cx_reg <= best_cent_reg.cx;
                                o_cy_reg <= best_cent_reg.cy;
                            end
                        end
                        else if (total_reg < TW'(MAX_CLUSTERS))
                        begin
                            o_status_reg <= lpc_pkg::ST_NEW;
                            o_idx_reg <= total_reg[IW-1:0];
                            o_cx_reg <= px_reg;
                            o_cy_reg <= py_reg;
                            total_reg <= total_reg + 1'b1;
                        end
                        else
                        begin
                            o_status_reg <= lpc_pkg::ST_FULL;
                            o_idx_reg <= '0;
                            o_cx_reg <= '0;
                            o_cy_reg <= '0;
                        end
                    end
                end
                S_JREAD:
                    state_reg <= S_JUPD;
                S_JUPD:
                begin
                    if (acc_rd_reg.cnt == CMAX)
                    begin
                        o_valid_reg <= 1'b1;
                        o_status_reg <= lpc_pkg::ST_SATURATED;
                        o_idx_reg <= idx_reg;
                        o_cx_reg <= best_cent_reg.cx;
                        o_cy_reg <= best_cent_reg.cy;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        acc_new_reg.sx <= acc_rd_reg.sx + SW'(px_reg);
                        acc_new_reg.sy <= acc_rd_reg.sy + SW'(py_reg);
                        acc_new_reg.cnt <= acc_rd_reg.cnt + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    neg_reg <= acc_new_reg.sx[SW-1];
                    num_reg <= num_abs;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dcnt_reg <= '0;
                    state_reg <= S_DIVX;
                end
                S_DIVX, S_DIVY:
                begin
                    if (dcnt_reg == DCW'(QW))
                    begin
                        if (state_reg == S_DIVX)
                        begin
                            qx_reg <= q_signed;
                            neg_reg <= acc_new_reg.sy[SW-1];
                            num_reg <= acc_new_reg.sy[SW-1] ? QW'(-acc_new_reg.sy)
                                                            : QW'(acc_new_reg.sy);
                            rem_reg <= '0;
                            quo_reg <= '0;
                            dcnt_reg <= '0;
                            state_reg <= S_DIVY;
                        end
                        else
                        begin
                            o_valid_reg <= 1'b1;
                            o_status_reg <= lpc_pkg::ST_JOINED;
                            o_idx_reg <= idx_reg;
                            o_cx_reg <= qx_reg;
                            o_cy_reg <= q_signed;
                            state_reg <= S_WRITE;
                        end
                    end
                    else
                    begin
                        num_reg <= {num_reg[QW-2:0], 1'b0};
                        dcnt_reg <= dcnt_reg + 1'b1;
                        if (rem_sh >= {1'b0, acc_new_reg.cnt})
                        begin
                            rem_reg <= rem_sub[COUNT_WIDTH-1:0];
                            quo_reg <= {quo_reg[QW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[COUNT_WIDTH-1:0];
                            quo_reg <= {quo_reg[QW-2:0], 1'b0};
                        end
                    end
                end
                S_WRITE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### design/lpc_checker.sv
// port checker for the leader point clustering block, bound to the top level
// depends on leader_point_clustering_top_assert.svh
`include "leader_point_clustering_top_assert.svh"

module lpc_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [2:0] status
);
    `LPC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `LPC_ASSERT_IMPL(a_no_take_while_out, clk, rst_n, !(s_axis_tready && m_axis_tvalid))
    `LPC_ASSERT_IMPL(a_status_code, clk, rst_n, !m_axis_tvalid || status <= 3'd5)
    `LPC_ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready)
endmodule

bind leader_point_clustering_top lpc_checker u_lpc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .status(m_axis_tdata[8:6])
);

### tb/tb_top.sv
// self-checking testbench for leader_point_clustering_top: point stream in, cluster results out
// keeps its own cluster table model and checks every result transfer in order
// depends on lpc_pkg and the design files
module tb_top;

    localparam int CLUSTERS = 64;
    localparam int CW       = 24;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = lpc_pkg::DIST_WIDTH;
    localparam longint CNT_LIMIT = (64'sd1 <<< CNT_W) - 1;
    localparam longint CMAX = 8388607;
    localparam longint CMIN = -8388608;

    typedef struct {
        logic                 kind;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
    } point_item_t;

    typedef struct {
        logic [5:0]           idx;
        lpc_pkg::status_t     st;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [6:0]           total;
    } cluster_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    leader_point_clustering_top #(
        .MAX_CLUSTERS(CLUSTERS),
        .COORD_WIDTH (CW),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // model of the cluster table
    longint cent_x [CLUSTERS];
    longint cent_y [CLUSTERS];
    longint total_x [CLUSTERS];
    longint total_y [CLUSTERS];
    longint members [CLUSTERS];
    int     clusters_held;
    longint join_radius;

    point_item_t     pending_points [$];
    cluster_result_t expected_results [$];
    longint          added_x [$];
    longint          added_y [$];
    int              mismatches;
    int              send_gap;
    int              recv_stall;
    bit              send_idling;
    bit              recv_idling;

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function automatic cluster_result_t cluster_step(point_item_t it);
        cluster_result_t r;
        longint px;
        longint py;
        longint best;
        longint d;
        int     hit;
        px = it.px;
        py = it.py;
        r.idx = '0;
        r.cx = '0;
        r.cy = '0;
        hit = -1;
        if (it.kind == lpc_pkg::KIND_ADD)
        begin
            for (int i = 0; i < clusters_held; i++)
            begin
                if (hit < 0 && sq_dist(cent_x[i], cent_y[i], px, py) < join_radius * join_radius)
                    hit = i;
            end
            if (hit >= 0)
            begin
                if (members[hit] >= CNT_LIMIT)
                begin
                    r.st = lpc_pkg::ST_SATURATED;
                end
                else
                begin
                    members[hit]++;
                    total_x[hit] += px;
                    total_y[hit] += py;
                    cent_x[hit] = total_x[hit] / members[hit];
                    cent_y[hit] = total_y[hit] / members[hit];
                    r.st = lpc_pkg::ST_JOINED;
                end
                r.idx = 6'(hit);
                r.cx = CW'(cent_x[hit]);
                r.cy = CW'(cent_y[hit]);
            end
            else if (clusters_held < CLUSTERS)
            begin
                cent_x[clusters_held] = px;
                cent_y[clusters_held] = py;
                total_x[clusters_held] = px;
                total_y[clusters_held] = py;
                members[clusters_held] = 1;
                r.idx = 6'(clusters_held);
                r.cx = CW'(px);
                r.cy = CW'(py);
                r.st = lpc_pkg::ST_NEW;
                clusters_held++;
            end
            else
            begin
                r.st = lpc_pkg::ST_FULL;
            end
        end
        else if (clusters_held == 0)
        begin
            r.st = lpc_pkg::ST_EMPTY;
        end
        else
        begin
            hit = 0;
            best = sq_dist(cent_x[0], cent_y[0], px, py);
            for (int i = 1; i < clusters_held; i++)
            begin
                d = sq_dist(cent_x[i], cent_y[i], px, py);
                if (d < best)
                begin
                    best = d;
                    hit = i;
                end
            end
            r.st = lpc_pkg::ST_NEAREST;
            r.idx = 6'(hit);
            r.cx = CW'(cent_x[hit]);
            r.cy = CW'(cent_y[hit]);
        end
        r.total = 7'(clusters_held);
        return r;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // input side driver
    always @(posedge clk or negedge rst_n)
    begin
        point_item_t nxt;
        bit          load;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            send_gap      <= 0;
            send_idling   <= 1'b1;
        end
        else
        begin
            load = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.insert(expected_results.size(), cluster_step('{s_axis_tuser,
                    s_axis_tdata[23:0], s_axis_tdata[47:24]}));
                if ($urandom_range(0, 99) < 3)
                    send_idling <= ~send_idling;
                if (send_idling && $urandom_range(0, 1))
                    send_gap <= $urandom_range(1, 13);
                else if (pending_points.size() > 0)
                    load = 1'b1;
                if (!load)
                    s_axis_tvalid <= 1'b0;
            end
            else if (!s_axis_tvalid)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (pending_points.size() > 0)
                    load = 1'b1;
            end
            if (load)
            begin
                nxt = pending_points.pop_front();
                s_axis_tdata  <= {nxt.py, nxt.px};
                s_axis_tuser  <= nxt.kind;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // result side monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        cluster_result_t got;
        cluster_result_t exp_r;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
            recv_idling   <= 1'b1;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.idx   = m_axis_tdata[5:0];
                got.st    = lpc_pkg::status_t'(m_axis_tdata[8:6]);
                got.cx    = m_axis_tdata[32:9];
                got.cy    = m_axis_tdata[56:33];
                got.total = m_axis_tdata[63:57];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %h", m_axis_tdata);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.idx !== exp_r.idx || got.st !== exp_r.st || got.cx !== exp_r.cx
                        || got.cy !== exp_r.cy || got.total !== exp_r.total)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected idx %0d st %0d c (%0d,%0d) n %0d,",
                                " got idx %0d st %0d c (%0d,%0d) n %0d"},
                                exp_r.idx, exp_r.st, exp_r.cx, exp_r.cy, exp_r.total,
                                got.idx, got.st, got.cx, got.cy, got.total);
                    end
                end
                if ($urandom_range(0, 99) < 3)
                    recv_idling <= ~recv_idling;
                if (recv_idling)
                begin
                    recv_stall <= $urandom_range(0, 13);
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_point(logic kind, longint x, longint y);
        point_item_t it;
        it.kind = kind;
        it.px = CW'(x);
        it.py = CW'(y);
        pending_points.insert(pending_points.size(), it);
        if (kind == lpc_pkg::KIND_ADD)
        begin
            added_x.insert(added_x.size(), x);
            added_y.insert(added_y.size(), y);
        end
    endtask

    task automatic wait_idle();
        while (pending_points.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic write_radius(longint value);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
        join_radius = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic longint clamp_coord(longint v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v;
    endfunction

    task automatic random_phase(int count);
        longint span;
        int     k;
        span = (join_radius > 100000) ? 100000 : join_radius + 2;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                queue_point(lpc_pkg::KIND_NEAREST, $signed(CW'($urandom)), $signed(CW'($urandom)));
            end
            else if (added_x.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                k = int'($urandom_range(0, added_x.size() - 1));
                queue_point(lpc_pkg::KIND_ADD,
                    clamp_coord(added_x[k] + longint'($urandom_range(0, 32'(2 * span))) - span),
                    clamp_coord(added_y[k] + longint'($urandom_range(0, 32'(2 * span))) - span));
            end
            else
            begin
                queue_point(lpc_pkg::KIND_ADD, $signed(CW'($urandom)), $signed(CW'($urandom)));
            end
        end
    endtask

    initial
    begin
        longint radii [6];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        clusters_held = 0;
        join_radius = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, zero radius, coordinate extremes
        write_radius(0);
        queue_point(lpc_pkg::KIND_NEAREST, 0, 0);
        queue_point(lpc_pkg::KIND_ADD, 0, 0);
        queue_point(lpc_pkg::KIND_ADD, 0, 0);
        queue_point(lpc_pkg::KIND_ADD, CMAX, CMAX);
        queue_point(lpc_pkg::KIND_ADD, CMIN, CMIN);
        queue_point(lpc_pkg::KIND_ADD, CMAX, CMIN);
        queue_point(lpc_pkg::KIND_ADD, CMIN, CMAX);
        queue_point(lpc_pkg::KIND_NEAREST, CMAX, CMAX);
        queue_point(lpc_pkg::KIND_NEAREST, CMIN, 0);
        queue_point(lpc_pkg::KIND_NEAREST, 1, 1);
        wait_idle();

        // widest radius: repeated joins into one cluster
        write_radius(CMAX);
        for (int i = 0; i < 14; i++)
            queue_point(lpc_pkg::KIND_ADD, (i % 2) ? -3 : 5, (i % 3) - 1);
        queue_point(lpc_pkg::KIND_NEAREST, 2, 2);
        wait_idle();

        radii = '{1, 256, 4096, 0, 300000, CMAX};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_radius(ph == 4 ? longint'($urandom_range(1, 32'(CMAX))) : radii[ph]);
            random_phase(245);
            wait_idle();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/lpc_pkg.sv
design/leader_point_clustering_top.sv
design/lpc_checker.sv
tb/tb_top.sv
